FILE: design/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg
// Shared widths, constants and register indexes of the frame rate meter.
// ----------------------------------------------------------------------------
package frm_pkg;

    localparam int INTERVAL_W = 24;
    localparam int RATE_W = 22;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int SAMPLE_SLOTS_DEF = 64;

    localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST = 24'd1000;
    localparam logic [INTERVAL_W-1:0] SKIP_BELOW_RST = 24'd8000;

    localparam logic REG_MIN_INTERVAL = 1'b0;
    localparam logic REG_SKIP_BELOW = 1'b1;

    // Quotient width: the raw rate never exceeds the numerator constant.
    localparam int QUO_W = 28;
    localparam logic [QUO_W-1:0] RATE_NUMERATOR = 28'd256000000;

    localparam logic [QUO_W-1:0] RATE_MIN_Q8 = 28'd26;
    localparam logic [QUO_W-1:0] RATE_MAX_Q8 = 28'd2559744;

    // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for every x below 2^32.
    localparam int MIX_W = 29;
    localparam int DIV10_SHIFT = 35;
    localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;
    localparam int PROD_W = MIX_W + 32;
    localparam int DIV10_Q_W = 26;

endpackage

FILE: design/frm_ram.sv
// ----------------------------------------------------------------------------
// frm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/frame_rate_averaging_meter.sv
// ----------------------------------------------------------------------------
// frame_rate_averaging_meter
// Moving-average frame rate meter over a circular store of frame intervals.
// ----------------------------------------------------------------------------
// One item is taken at a time. An accepted interval passes from acceptance
// through the store update, the 28-step restoring divider that forms the
// mean rate and the mix, scale and clamp states to its result; a skipped
// interval goes straight to its result. The next item is taken as soon as
// the result is handed to the output register, even while that result still
// waits there. The interval store is a single RAM whose unwritten entries are
// tracked by the fill count, so no clearing pass runs after reset.
module frame_rate_averaging_meter #(
    parameter int SAMPLE_SLOTS = frm_pkg::SAMPLE_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [frm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [frm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [frm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [frm_pkg::INTERVAL_W-1:0]   interval_us,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [frm_pkg::RATE_W-1:0]       rate_q8,
    output logic                             updated
);

    import frm_pkg::*;

    localparam int SLOT_W = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(SAMPLE_SLOTS + 1);
    localparam int SUM_W = INTERVAL_W + $clog2(SAMPLE_SLOTS);
    localparam int NUM_W = CNT_W + QUO_W;
    localparam int DCNT_W = $clog2(QUO_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_MIX   = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_CLAMP = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    logic [2:0]            state_reg;
    logic [INTERVAL_W-1:0] min_reg;
    logic [INTERVAL_W-1:0] skip_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [INTERVAL_W-1:0] v_reg;
    logic [SUM_W-1:0]      rem_reg;
    logic [QUO_W-1:0]      dq_reg;
    logic [DCNT_W-1:0]     dcnt_reg;
    logic [MIX_W-1:0]      mix_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [RATE_W-1:0]     res_rate_reg;
    logic                  res_upd_reg;
    logic                  out_valid_reg;
    logic [RATE_W-1:0]     out_rate_reg;
    logic                  out_upd_reg;

    logic                  cfg_write;
    logic                  in_accept;
    logic                  out_free;
    logic [INTERVAL_W-1:0] lo;
    logic [INTERVAL_W-1:0] v_next;
    logic                  skip_item;
    logic [INTERVAL_W-1:0] old_data;
    logic                  store_full;
    logic [SUM_W-1:0]      sum_next;
    logic [NUM_W-1:0]      numerator;
    logic [SUM_W:0]        trial;
    logic                  trial_ge;
    logic [MIX_W-1:0]      mix_next;
    logic [QUO_W-1:0]      tenth;
    logic [QUO_W-1:0]      pick;
    logic [QUO_W-1:0]      clamped;

    // Configuration port.
    assign cfg_write = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SKIP_BELOW)
                    ? {{(CFG_DATA_W-INTERVAL_W){1'b0}}, skip_reg}
                    : {{(CFG_DATA_W-INTERVAL_W){1'b0}}, min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_INTERVAL_RST;
            skip_reg <= SKIP_BELOW_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MIN_INTERVAL)
            begin
                min_reg <= pwdata[INTERVAL_W-1:0];
            end
            else
            begin
                skip_reg <= pwdata[INTERVAL_W-1:0];
            end
        end
    end

    // Input clamp and skip decision.
    assign lo = (min_reg == '0) ? INTERVAL_W'(1) : min_reg;
    assign v_next = (interval_us < lo) ? lo : interval_us;
    assign skip_item = v_next < skip_reg;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // The fill count tracks written entries, so an entry was written before exactly
    // when the store is already full.
    assign store_full = (count_reg == CNT_W'(SAMPLE_SLOTS));
    assign sum_next = sum_reg - (store_full ? SUM_W'(old_data) : '0) + SUM_W'(v_reg);

    frm_ram #(
        .WIDTH (INTERVAL_W),
        .DEPTH (SAMPLE_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (state_reg == ST_UPD),
        .waddr (slot_reg),
        .wdata (v_reg),
        .raddr (slot_reg),
        .rdata (old_data)
    );

    assign numerator = NUM_W'(count_reg) * NUM_W'(RATE_NUMERATOR);
    assign trial = {rem_reg, dq_reg[QUO_W-1]};
    assign trial_ge = trial >= {1'b0, sum_reg};

    assign mix_next = (MIX_W'(rate_reg) << 3) + MIX_W'(rate_reg) + MIX_W'(dq_reg);
    assign tenth = QUO_W'(prod_reg[DIV10_SHIFT +: DIV10_Q_W]);
    assign pick = (rate_reg == '0) ? dq_reg : tenth;
    assign clamped = (pick < RATE_MIN_Q8) ? RATE_MIN_Q8
                   : ((pick > RATE_MAX_Q8) ? RATE_MAX_Q8 : pick);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg <= '0;
            sum_reg <= '0;
            count_reg <= '0;
            rate_reg <= '0;
            dcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= skip_item ? ST_DONE : ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    sum_reg <= sum_next;
                    if (!store_full)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    slot_reg <= (slot_reg == SLOT_W'(SAMPLE_SLOTS - 1))
                                ? '0 : slot_reg + SLOT_W'(1);
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    dcnt_reg <= DCNT_W'(QUO_W - 1);
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg - DCNT_W'(1);
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    state_reg <= ST_CLAMP;
                end
                ST_CLAMP:
                begin
                    rate_reg <= RATE_W'(clamped);
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                v_reg <= v_next;
                res_rate_reg <= rate_reg;
                res_upd_reg <= 1'b0;
            end
            ST_MUL:
            begin
                rem_reg <= SUM_W'(numerator[NUM_W-1:QUO_W]);
                dq_reg <= numerator[QUO_W-1:0];
            end
            ST_DIV:
            begin
                rem_reg <= trial_ge ? SUM_W'(trial - {1'b0, sum_reg}) : trial[SUM_W-1:0];
                dq_reg <= {dq_reg[QUO_W-2:0], trial_ge};
            end
            ST_MIX:
            begin
                mix_reg <= mix_next;
            end
            ST_SCALE:
            begin
                prod_reg <= PROD_W'(mix_reg) * PROD_W'(DIV10_MUL);
            end
            ST_CLAMP:
            begin
                res_rate_reg <= RATE_W'(clamped);
                res_upd_reg <= 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_rate_reg <= res_rate_reg;
                    out_upd_reg <= res_upd_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign rate_q8 = out_rate_reg;
    assign updated = out_upd_reg;

endmodule

FILE: design/frm_checker.sv
// ----------------------------------------------------------------------------
// frm_checker
// Port-level checks of the frame rate meter, bound to its top level.
// ----------------------------------------------------------------------------
module frm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           pready,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [frm_pkg::RATE_W-1:0]     rate_q8
);

    import frm_pkg::*;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rate_q8))
    else $error("Stalled result item changed or vanished.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> QUO_W'(rate_q8) <= RATE_MAX_Q8)
    else $error("Reported rate above the upper clamp.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rate_q8 != '0) |-> QUO_W'(rate_q8) >= RATE_MIN_Q8)
    else $error("Nonzero reported rate below the lower clamp.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("Configuration port inserted a wait state.");

endmodule

bind frame_rate_averaging_meter frm_checker u_frm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .rate_q8   (rate_q8)
);
